### design/triangle_edge_rasterizer_defines.svh
// ----------------------------------------------------------------------------
// Triangle edge rasterizer assertion macros
// Shared property forms for the checker.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_EDGE_RASTERIZER_DEFINES_SVH
`define TRIANGLE_EDGE_RASTERIZER_DEFINES_SVH

// Same-cycle implication.
`define TER_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define TER_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### design/ter_pkg.sv
// ----------------------------------------------------------------------------
// Triangle edge rasterizer package
// Constants and controller/datapath interface types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package ter_pkg;

  localparam int FRAC_BITS  = 14;
  localparam int MAX_SCREEN = 4096;
  localparam int COORD_W    = 16;
  localparam int SIZE_W     = 13;
  localparam int PIX_W      = 12;
  localparam int ADDR_W     = 26;
  localparam int DIVD_W     = SIZE_W + FRAC_BITS + 1;
  localparam int QUO_W      = FRAC_BITS + 3;

  localparam logic [SIZE_W-1:0] RESET_WIDTH  = 13'd640;
  localparam logic [SIZE_W-1:0] RESET_HEIGHT = 13'd480;

  localparam logic REG_SCREEN_WIDTH  = 1'b0;
  localparam logic REG_SCREEN_HEIGHT = 1'b1;

  localparam logic MODE_LOAD = 1'b0;

  localparam logic [1:0] RES_LOAD  = 2'd0;
  localparam logic [1:0] RES_DONE  = 2'd1;
  localparam logic [1:0] RES_PIXEL = 2'd2;

  typedef struct packed {
    logic       capture;
    logic       box_mul;
    logic [1:0] box_sel;
    logic       div_start;
    logic       div_store;
    logic [1:0] div_sel;
    logic       walk_mul;
    logic       emit;
    logic [1:0] emit_kind;
  } ter_cmd_t;

  typedef struct packed {
    logic walk_done;
    logic div_done;
    logic out_free;
  } ter_status_t;

endpackage

### design/triangle_edge_rasterizer.sv
// ----------------------------------------------------------------------------
// Triangle edge rasterizer
// Edge-function coverage test over a triangle's screen bounding box.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall): mode 0 loads triangle A, B, C in signed
// Q2.14 device coordinates; mode 1 visits the next bounding-box pixel in row
// order. Every request yields exactly one result on the output channel
// (out_valid/out_stall): pixel_x, pixel_y, byte_address, write_enable, last.
// A load runs box setup (one shared multiplier, one corner per cycle), four
// divisions by the latched width and height (start, 28 quotient bits,
// store) and an output step. A walk request computes edge products, then
// the sign test and address; a request on a finished walk goes straight
// to the output step.
// One request is in flight at a time; the next one is taken while the
// previous result still sits in the output register.
// cfg_we writes screen_width (index 0) or screen_height (index 1); the size
// is latched at each load. Reset sets 640x480, an empty box, no result.
// While out_stall is high a valid result holds and work stops at the final step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module triangle_edge_rasterizer (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic                               cfg_index,
  input  logic [ter_pkg::SIZE_W-1:0]         cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               mode,
  input  logic signed [ter_pkg::COORD_W-1:0] ax,
  input  logic signed [ter_pkg::COORD_W-1:0] ay,
  input  logic signed [ter_pkg::COORD_W-1:0] bx,
  input  logic signed [ter_pkg::COORD_W-1:0] by_coord,
  input  logic signed [ter_pkg::COORD_W-1:0] cx,
  input  logic signed [ter_pkg::COORD_W-1:0] cy,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [ter_pkg::PIX_W-1:0]          pixel_x,
  output logic [ter_pkg::PIX_W-1:0]          pixel_y,
  output logic [ter_pkg::ADDR_W-1:0]         byte_address,
  output logic                               write_enable,
  output logic                               last
);

  ter_pkg::ter_cmd_t    cmd;
  ter_pkg::ter_status_t status;

  ter_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .mode     (mode),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  ter_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .ax           (ax),
    .ay           (ay),
    .bx           (bx),
    .by_coord     (by_coord),
    .cx           (cx),
    .cy           (cy),
    .cmd          (cmd),
    .status       (status),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .byte_address (byte_address),
    .write_enable (write_enable),
    .last         (last)
  );

endmodule

### design/ter_divider.sv
// ----------------------------------------------------------------------------
// Triangle edge rasterizer divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module ter_divider (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [ter_pkg::DIVD_W-1:0]      dividend,
  input  logic [ter_pkg::SIZE_W-1:0]      divisor,
  output logic                            done,
  output logic [ter_pkg::DIVD_W-1:0]      quotient,
  output logic [ter_pkg::SIZE_W-1:0]      remainder
);

  localparam int CNT_W = $clog2(ter_pkg::DIVD_W + 1);

  logic [CNT_W-1:0]            count;
  logic                        busy;
  logic [ter_pkg::DIVD_W-1:0]  shreg;
  logic [ter_pkg::SIZE_W-1:0]  dsr;
  logic [ter_pkg::SIZE_W:0]    trial;
  logic [ter_pkg::SIZE_W:0]    diff;

  assign trial = {remainder, shreg[ter_pkg::DIVD_W-1]};
  assign diff  = trial - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CNT_W'(ter_pkg::DIVD_W);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg     <= dividend;
      dsr       <= divisor;
      remainder <= '0;
      quotient  <= '0;
    end else if (busy) begin
      shreg <= {shreg[ter_pkg::DIVD_W-2:0], 1'b0};
      if (!diff[ter_pkg::SIZE_W]) begin
        remainder <= diff[ter_pkg::SIZE_W-1:0];
        quotient  <= {quotient[ter_pkg::DIVD_W-2:0], 1'b1};
      end else begin
        remainder <= trial[ter_pkg::SIZE_W-1:0];
        quotient  <= {quotient[ter_pkg::DIVD_W-2:0], 1'b0};
      end
    end
  end

endmodule

### design/ter_ctrl.sv
// ----------------------------------------------------------------------------
// Triangle edge rasterizer controller
// Sequences load setup, divisions and the per-pixel walk.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module ter_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 mode,
  output logic                 in_stall,
  input  ter_pkg::ter_status_t status,
  output ter_pkg::ter_cmd_t    cmd
);

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_BOX       = 3'd1;
  localparam logic [2:0] S_DIV_START = 3'd2;
  localparam logic [2:0] S_DIV_WAIT  = 3'd3;
  localparam logic [2:0] S_LOAD_OUT  = 3'd4;
  localparam logic [2:0] S_WALK_MUL  = 3'd5;
  localparam logic [2:0] S_WALK_OUT  = 3'd6;
  localparam logic [2:0] S_DONE_OUT  = 3'd7;

  logic [2:0] state, state_next;
  logic [2:0] cnt, cnt_next;
  logic [1:0] didx, didx_next;
  logic       accept;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    didx_next  = didx;
    cmd        = '0;
    cmd.box_sel = cnt[1:0];
    cmd.div_sel = didx;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (mode == ter_pkg::MODE_LOAD) begin
            cmd.capture = 1'b1;
            cnt_next    = '0;
            state_next  = S_BOX;
          end else if (status.walk_done) begin
            state_next = S_DONE_OUT;
          end else begin
            state_next = S_WALK_MUL;
          end
        end
      end
      S_BOX: begin
        cmd.box_mul = !cnt[2];
        cnt_next    = cnt + 1'b1;
        if (cnt[2]) begin
          didx_next  = '0;
          state_next = S_DIV_START;
        end
      end
      S_DIV_START: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (status.div_done) begin
          cmd.div_store = 1'b1;
          didx_next     = didx + 1'b1;
          state_next    = (didx == 2'd3) ? S_LOAD_OUT : S_DIV_START;
        end
      end
      S_LOAD_OUT: begin
        if (status.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = ter_pkg::RES_LOAD;
          state_next    = S_IDLE;
        end
      end
      S_WALK_MUL: begin
        cmd.walk_mul = 1'b1;
        state_next   = S_WALK_OUT;
      end
      S_WALK_OUT: begin
        if (status.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = ter_pkg::RES_PIXEL;
          state_next    = S_IDLE;
        end
      end
      S_DONE_OUT: begin
        if (status.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = ter_pkg::RES_DONE;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      didx  <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      didx  <= didx_next;
    end
  end

endmodule

### design/ter_dpath.sv
// ----------------------------------------------------------------------------
// Triangle edge rasterizer datapath
// Vertex store, box setup, incremental sample points, edge tests, output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module ter_dpath (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [ter_pkg::SIZE_W-1:0]        cfg_data,
  input  logic signed [ter_pkg::COORD_W-1:0] ax,
  input  logic signed [ter_pkg::COORD_W-1:0] ay,
  input  logic signed [ter_pkg::COORD_W-1:0] bx,
  input  logic signed [ter_pkg::COORD_W-1:0] by_coord,
  input  logic signed [ter_pkg::COORD_W-1:0] cx,
  input  logic signed [ter_pkg::COORD_W-1:0] cy,
  input  ter_pkg::ter_cmd_t                 cmd,
  output ter_pkg::ter_status_t              status,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [ter_pkg::PIX_W-1:0]         pixel_x,
  output logic [ter_pkg::PIX_W-1:0]         pixel_y,
  output logic [ter_pkg::ADDR_W-1:0]        byte_address,
  output logic                              write_enable,
  output logic                              last
);

  localparam int SW = ter_pkg::SIZE_W;
  localparam int CW = ter_pkg::COORD_W;
  localparam int QW = ter_pkg::QUO_W;
  localparam int PW = 2 * SW + ter_pkg::FRAC_BITS - 9;

  logic [SW-1:0] screen_width, screen_height, lat_w, lat_h;
  logic signed [CW-1:0] vx [3];
  logic signed [CW-1:0] vy [3];
  logic signed [CW:0]   ex [3];
  logic signed [CW:0]   ey [3];
  logic signed [CW-1:0] xmin, xmax, ymin, ymax;
  logic signed [CW-1:0] in_xmin, in_xmax, in_ymin, in_ymax;
  logic signed [CW-1:0] t0, t1, t2, t3;

  logic [SW-1:0] box_x_start, box_x_end, box_y_end, walk_x, walk_y;

  // box setup
  logic signed [CW-1:0] bv;
  logic [SW-1:0]        blim;
  logic signed [CW:0]   bfac;
  logic signed [PW-1:0] bprod, bprod_q;
  logic [SW-1:0]        blim_q;
  logic [1:0]           bsel_q;
  logic                 bwr_q;
  logic [PW-ter_pkg::FRAC_BITS-1:0] bq;
  logic [SW-1:0]        bres;

  // divider
  logic [SW-1:0]              dnum, dlim;
  logic                       ddone;
  logic [ter_pkg::DIVD_W-1:0] dquo;
  logic [SW-1:0]              drem;

  // sample accumulators
  logic [QW-1:0] qx, qx0, qsx, qy, qsy;
  logic [SW-1:0] rx, rx0, rsx, ry, rsy;
  logic [SW:0]   rx_sum, ry_sum;
  logic          rx_wrap, ry_wrap;

  // edge stage
  logic signed [QW:0]    px, py;
  logic signed [QW+1:0]  fx [3];
  logic signed [QW+1:0]  fy [3];
  logic signed [CW+QW+2:0] pa_q [3];
  logic signed [CW+QW+2:0] pb_q [3];
  logic signed [CW+QW+3:0] ev [3];
  logic [ter_pkg::ADDR_W-1:0] base_q, addr_sum;
  logic [SW-1:0] x_q, y_q;
  logic          onscr_q;
  logic          pos, neg;

  logic [SW-1:0] wx_next, wy_next;
  logic          row_wrap;

  assign status.out_free  = !out_valid || !out_stall;
  assign status.div_done  = ddone;
  assign status.walk_done = (walk_y >= box_y_end) || (box_x_start >= box_x_end);

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= ter_pkg::RESET_WIDTH;
      screen_height <= ter_pkg::RESET_HEIGHT;
    end else if (cfg_we) begin
      if (cfg_index == ter_pkg::REG_SCREEN_WIDTH) screen_width <= cfg_data;
      else screen_height <= cfg_data;
    end
  end

  assign t0 = (ax < bx) ? ax : bx;
  assign t1 = (ax > bx) ? ax : bx;
  assign t2 = (ay < by_coord) ? ay : by_coord;
  assign t3 = (ay > by_coord) ? ay : by_coord;
  assign in_xmin = (cx < t0) ? cx : t0;
  assign in_xmax = (cx > t1) ? cx : t1;
  assign in_ymin = (cy < t2) ? cy : t2;
  assign in_ymax = (cy > t3) ? cy : t3;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      vx[0] <= ax; vy[0] <= ay;
      vx[1] <= bx; vy[1] <= by_coord;
      vx[2] <= cx; vy[2] <= cy;
      ex[0] <= (CW+1)'(ax) - (CW+1)'(bx);
      ey[0] <= (CW+1)'(ay) - (CW+1)'(by_coord);
      ex[1] <= (CW+1)'(bx) - (CW+1)'(cx);
      ey[1] <= (CW+1)'(by_coord) - (CW+1)'(cy);
      ex[2] <= (CW+1)'(cx) - (CW+1)'(ax);
      ey[2] <= (CW+1)'(cy) - (CW+1)'(ay);
      xmin <= in_xmin; xmax <= in_xmax;
      ymin <= in_ymin; ymax <= in_ymax;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lat_w <= '0;
      lat_h <= '0;
    end else if (cmd.capture) begin
      lat_w <= (screen_width > SW'(ter_pkg::MAX_SCREEN)) ? SW'(ter_pkg::MAX_SCREEN)
                                                         : screen_width;
      lat_h <= (screen_height > SW'(ter_pkg::MAX_SCREEN)) ? SW'(ter_pkg::MAX_SCREEN)
                                                          : screen_height;
    end
  end

  // box corner: floor(half*(2^F + v) / 2^F), clamped to [0, lim]
  always_comb begin
    case (cmd.box_sel)
      2'd0:    bv = xmin;
      2'd1:    bv = xmax;
      2'd2:    bv = ymin;
      default: bv = ymax;
    endcase
  end
  assign blim  = cmd.box_sel[1] ? lat_h : lat_w;
  assign bfac  = (CW+1)'(1 << ter_pkg::FRAC_BITS) + (CW+1)'(bv);
  assign bprod = PW'($signed({1'b0, blim[SW-1:1]})) * PW'(bfac);
  assign bq    = bprod_q[PW-1:ter_pkg::FRAC_BITS];
  assign bres  = bprod_q[PW-1] ? '0 :
                 (bq > (PW-ter_pkg::FRAC_BITS)'(blim_q)) ? blim_q : bq[SW-1:0];

  always_ff @(posedge clk) begin
    bprod_q <= bprod;
    blim_q  <= blim;
    bsel_q  <= cmd.box_sel;
  end

  always_ff @(posedge clk) begin
    if (rst) bwr_q <= 1'b0;
    else     bwr_q <= cmd.box_mul;
  end

  // divider operands: 2^(F+1)*c / lim
  always_comb begin
    case (cmd.div_sel)
      2'd0:    dnum = box_x_start;
      2'd2:    dnum = walk_y;
      default: dnum = SW'(1);
    endcase
  end
  assign dlim = cmd.div_sel[1] ? lat_h : lat_w;

  ter_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  ({dnum, (ter_pkg::FRAC_BITS + 1)'(0)}),
    .divisor   (dlim),
    .done      (ddone),
    .quotient  (dquo),
    .remainder (drem)
  );

  // walk advance
  assign wx_next  = walk_x + 1'b1;
  assign row_wrap = (wx_next >= box_x_end);
  assign wy_next  = row_wrap ? walk_y + 1'b1 : walk_y;
  assign rx_sum   = {1'b0, rx} + {1'b0, rsx};
  assign rx_wrap  = (rx_sum >= {1'b0, lat_w});
  assign ry_sum   = {1'b0, ry} + {1'b0, rsy};
  assign ry_wrap  = (ry_sum >= {1'b0, lat_h});

  always_ff @(posedge clk) begin
    if (rst) begin
      box_x_start <= '0;
      box_x_end   <= '0;
      box_y_end   <= '0;
      walk_x      <= '0;
      walk_y      <= '0;
    end else if (bwr_q) begin
      case (bsel_q)
        2'd0: begin
          box_x_start <= bres;
          walk_x      <= bres;
        end
        2'd1:    box_x_end <= bres;
        2'd2:    walk_y    <= bres;
        default: box_y_end <= bres;
      endcase
    end else if (cmd.emit && cmd.emit_kind == ter_pkg::RES_PIXEL) begin
      walk_x <= row_wrap ? box_x_start : wx_next;
      walk_y <= wy_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_store) begin
      case (cmd.div_sel)
        2'd0: begin
          qx0 <= dquo[QW-1:0]; rx0 <= drem;
          qx  <= dquo[QW-1:0]; rx  <= drem;
        end
        2'd1: begin
          qsx <= dquo[QW-1:0]; rsx <= drem;
        end
        2'd2: begin
          qy <= dquo[QW-1:0]; ry <= drem;
        end
        default: begin
          qsy <= dquo[QW-1:0]; rsy <= drem;
        end
      endcase
    end else if (cmd.emit && cmd.emit_kind == ter_pkg::RES_PIXEL) begin
      if (row_wrap) begin
        qx <= qx0;
        rx <= rx0;
        qy <= qy + qsy + QW'(ry_wrap);
        ry <= ry_wrap ? SW'(ry_sum - {1'b0, lat_h}) : ry_sum[SW-1:0];
      end else begin
        qx <= qx + qsx + QW'(rx_wrap);
        rx <= rx_wrap ? SW'(rx_sum - {1'b0, lat_w}) : rx_sum[SW-1:0];
      end
    end
  end

  // edge products
  assign px = $signed({1'b0, qx}) - (QW+1)'(1 << ter_pkg::FRAC_BITS);
  assign py = $signed({1'b0, qy}) - (QW+1)'(1 << ter_pkg::FRAC_BITS);

  for (genvar k = 0; k < 3; k++) begin : g_edge
    assign fx[k] = (QW+2)'(vx[k]) - (QW+2)'(px);
    assign fy[k] = (QW+2)'(vy[k]) - (QW+2)'(py);
    always_ff @(posedge clk) begin
      if (cmd.walk_mul) begin
        pa_q[k] <= (CW+QW+3)'(ex[k]) * (CW+QW+3)'(fy[k]);
        pb_q[k] <= (CW+QW+3)'(ey[k]) * (CW+QW+3)'(fx[k]);
      end
    end
    assign ev[k] = (CW+QW+4)'(pa_q[k]) - (CW+QW+4)'(pb_q[k]);
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_mul) begin
      base_q  <= ter_pkg::ADDR_W'(lat_w * walk_y);
      x_q     <= walk_x;
      y_q     <= walk_y;
      onscr_q <= (walk_x < lat_w) && (walk_y < lat_h);
    end
  end

  assign pos = (ev[0] > 0) && (ev[1] > 0) && (ev[2] > 0);
  assign neg = ev[0][CW+QW+3] && ev[1][CW+QW+3] && ev[2][CW+QW+3];
  assign addr_sum = base_q + ter_pkg::ADDR_W'(x_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      pixel_x      <= '0;
      pixel_y      <= '0;
      byte_address <= '0;
      write_enable <= 1'b0;
      last         <= 1'b0;
      case (cmd.emit_kind)
        ter_pkg::RES_DONE: last <= 1'b1;
        ter_pkg::RES_PIXEL: begin
          pixel_x      <= x_q[ter_pkg::PIX_W-1:0];
          pixel_y      <= y_q[ter_pkg::PIX_W-1:0];
          byte_address <= addr_sum + {addr_sum[ter_pkg::ADDR_W-2:0], 1'b0};
          write_enable <= (pos || neg) && onscr_q;
          last         <= (wy_next >= box_y_end) || (box_x_start >= box_x_end);
        end
        default: last <= 1'b0;
      endcase
    end
  end

endmodule

### design/ter_checker.sv
// ----------------------------------------------------------------------------
// Triangle edge rasterizer checker
// Port-level properties, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "triangle_edge_rasterizer_defines.svh"
module ter_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               cfg_we,
  input logic                               cfg_index,
  input logic [ter_pkg::SIZE_W-1:0]         cfg_data,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic                               mode,
  input logic signed [ter_pkg::COORD_W-1:0] ax,
  input logic signed [ter_pkg::COORD_W-1:0] ay,
  input logic signed [ter_pkg::COORD_W-1:0] bx,
  input logic signed [ter_pkg::COORD_W-1:0] by_coord,
  input logic signed [ter_pkg::COORD_W-1:0] cx,
  input logic signed [ter_pkg::COORD_W-1:0] cy,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic [ter_pkg::PIX_W-1:0]          pixel_x,
  input logic [ter_pkg::PIX_W-1:0]          pixel_y,
  input logic [ter_pkg::ADDR_W-1:0]         byte_address,
  input logic                               write_enable,
  input logic                               last
);

  `TER_ASSERT_NEXT(a_busy_after_request, in_valid && !in_stall, in_stall, "request not held off")
  `TER_ASSERT_NEXT(a_result_held, out_valid && out_stall, out_valid, "stalled result dropped")
  `TER_ASSERT_NOW(a_reset_clean, $past(rst), !out_valid && !in_stall, "not clean after reset")
  `TER_ASSERT_NEXT(a_load_no_write, in_valid && !in_stall && !mode, !out_valid || !write_enable || $past(out_valid), "load wrote a pixel")

endmodule

bind triangle_edge_rasterizer ter_checker u_ter_checker (.*);

### tb/sv/tb_triangle_edge_rasterizer.sv
// ----------------------------------------------------------------------------
// Triangle edge rasterizer testbench
// Loads triangles and walks their bounding boxes under random idling on both
// channels, checking each result against an edge-function pixel predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_triangle_edge_rasterizer;
  import ter_pkg::*;

  typedef struct packed {
    logic              mode;
    logic signed [15:0] ax, ay, bx, by, cx, cy;
  } request_t;

  typedef struct packed {
    logic [PIX_W-1:0]  px;
    logic [PIX_W-1:0]  py;
    logic [ADDR_W-1:0] addr;
    logic              we;
    logic              last;
  } pixel_t;

  localparam logic MODE_WALK = 1'b1;
  localparam longint CYCLE_LIMIT = 3000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_index = REG_SCREEN_WIDTH;
  logic [SIZE_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic mode = MODE_LOAD;
  logic signed [15:0] ax = '0, ay = '0, bx = '0, by_coord = '0, cx = '0, cy = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [PIX_W-1:0] pixel_x, pixel_y;
  logic [ADDR_W-1:0] byte_address;
  logic write_enable, last;

  triangle_edge_rasterizer i_dut (.*);

  always #1 clk = ~clk;

  // predictor state
  longint cur_w = 640, cur_h = 480;
  longint lat_w, lat_h;
  longint vtx [6];
  longint bx0, bx1, by1, wx, wy;

  request_t pending_q [$];
  pixel_t   pixel_q [$];
  int errors = 0;
  int mismatches = 0;
  bit quiet = 1'b0;
  bit hold_long = 1'b0;
  longint cycles = 0;

  function automatic longint screen_coord(longint v, longint lim);
    longint half, num, q;
    half = lim / 2;
    num = half * (1 << FRAC_BITS) + v * half;
    if (num < 0) return 0;
    q = num >>> FRAC_BITS;
    return (q > lim) ? lim : q;
  endfunction

  function automatic longint sample_coord(longint c, longint lim);
    if (lim == 0) return 0;
    return ((c << (FRAC_BITS + 1)) / lim) - (1 << FRAC_BITS);
  endfunction

  function automatic longint cross_edge(longint ux, longint uy, longint vx, longint vy,
                                        longint px, longint py);
    return (ux - vx) * (uy - py) - (uy - vy) * (ux - px);
  endfunction

  function automatic bit walk_finished();
    return wy >= by1 || bx0 >= bx1;
  endfunction

  function automatic pixel_t predict_pixel(request_t r);
    pixel_t o;
    longint v [6];
    longint xmin, xmax, ymin, ymax, spx, spy, e0, e1, e2;
    bit cov;
    o = '0;
    if (r.mode == MODE_LOAD) begin
      v = '{r.ax, r.ay, r.bx, r.by, r.cx, r.cy};
      vtx = v;
      lat_w = (cur_w > MAX_SCREEN) ? MAX_SCREEN : cur_w;
      lat_h = (cur_h > MAX_SCREEN) ? MAX_SCREEN : cur_h;
      xmin = v[0]; xmax = v[0]; ymin = v[1]; ymax = v[1];
      for (int i = 1; i < 3; i++) begin
        if (v[2*i] < xmin) xmin = v[2*i];
        if (v[2*i] > xmax) xmax = v[2*i];
        if (v[2*i+1] < ymin) ymin = v[2*i+1];
        if (v[2*i+1] > ymax) ymax = v[2*i+1];
      end
      bx0 = screen_coord(xmin, lat_w);
      bx1 = screen_coord(xmax, lat_w);
      by1 = screen_coord(ymax, lat_h);
      wx = bx0;
      wy = screen_coord(ymin, lat_h);
      return o;
    end
    if (walk_finished()) begin
      o.last = 1'b1;
      return o;
    end
    spx = sample_coord(wx, lat_w);
    spy = sample_coord(wy, lat_h);
    e0 = cross_edge(vtx[0], vtx[1], vtx[2], vtx[3], spx, spy);
    e1 = cross_edge(vtx[2], vtx[3], vtx[4], vtx[5], spx, spy);
    e2 = cross_edge(vtx[4], vtx[5], vtx[0], vtx[1], spx, spy);
    cov = (e0 > 0 && e1 > 0 && e2 > 0) || (e0 < 0 && e1 < 0 && e2 < 0);
    o.px = wx[PIX_W-1:0];
    o.py = wy[PIX_W-1:0];
    o.addr = ADDR_W'((lat_w * wy + wx) * 3);
    o.we = cov && wx < lat_w && wy < lat_h;
    wx = wx + 1;
    if (wx >= bx1) begin
      wx = bx0;
      wy = wy + 1;
    end
    o.last = walk_finished();
    return o;
  endfunction

  // driver
  int in_gap = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        pixel_q.push_back(predict_pixel(pending_q.pop_front()));
      end
      if (!in_valid || !in_stall) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          request_t r;
          r = pending_q[0];
          if (!quiet && $urandom_range(0, 9) == 0) begin
            in_gap <= $urandom_range(1, 18);
            in_valid <= 1'b0;
          end else begin
            in_valid <= 1'b1;
            mode <= r.mode;
            ax <= r.ax; ay <= r.ay; bx <= r.bx;
            by_coord <= r.by; cx <= r.cx; cy <= r.cy;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  int out_gap = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        pixel_t got, want;
        got = '{pixel_x, pixel_y, byte_address, write_enable, last};
        if (pixel_q.size() == 0) begin
          errors++;
          $display("unexpected result %p", got);
        end else begin
          want = pixel_q.pop_front();
          if (got !== want) begin
            errors++;
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
          end
        end
      end
      if (hold_long) out_stall <= 1'b1;
      else if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_gap <= $urandom_range(1, 18);
        out_stall <= 1'b1;
      end else out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_triangle_edge_rasterizer failed");
      $finish;
    end
  end

  function automatic logic signed [15:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'($urandom);
      default: return 16'($signed($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  task automatic add_load(logic signed [15:0] a0, a1, b0, b1, c0, c1);
    request_t r;
    r = '{MODE_LOAD, a0, a1, b0, b1, c0, c1};
    pending_q.push_back(r);
  endtask

  task automatic add_walk(int n);
    request_t r;
    for (int i = 0; i < n; i++) begin
      r = '{MODE_WALK, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
            16'($urandom), 16'($urandom)};
      pending_q.push_back(r);
    end
  endtask

  task automatic drain();
    wait (pending_q.size() == 0 && pixel_q.size() == 0);
    repeat (150) @(posedge clk);
  endtask

  task automatic write_size(logic idx, logic [SIZE_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    if (idx == REG_SCREEN_WIDTH) cur_w = val; else cur_h = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(int n);
    int w;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 7) == 0) add_load(rand_coord(), rand_coord(), rand_coord(),
                                             rand_coord(), rand_coord(), rand_coord());
      else add_load(16'($signed($urandom_range(0, 32768)) - 16384),
                    16'($signed($urandom_range(0, 32768)) - 16384),
                    16'($signed($urandom_range(0, 32768)) - 16384),
                    16'($signed($urandom_range(0, 32768)) - 16384),
                    16'($signed($urandom_range(0, 32768)) - 16384),
                    16'($signed($urandom_range(0, 32768)) - 16384));
      w = $urandom_range(5, 40);
      add_walk(w);
      i += w;
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    // power-on walk, then directed cases on a small screen
    add_walk(2);
    drain();
    write_size(REG_SCREEN_WIDTH, 13'd8);
    write_size(REG_SCREEN_HEIGHT, 13'd6);
    add_load(-16384, -16384, 16383, -16384, 0, 16383);
    add_walk(10);
    add_load(16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh7FFF);
    add_walk(8);
    add_load(0, 0, 0, 0, 0, 0);
    add_walk(2);
    drain();
    // change size mid-walk: no effect until next load
    add_load(-8000, -8000, 8000, -4000, 0, 8000);
    add_walk(3);
    drain();
    write_size(REG_SCREEN_WIDTH, 13'd0);
    add_walk(3);
    add_load(-8000, -8000, 8000, -4000, 0, 8000);
    add_walk(2);
    drain();
    write_size(REG_SCREEN_WIDTH, 13'h1FFF);
    write_size(REG_SCREEN_HEIGHT, 13'd1);
    add_load(-16384, -100, 16384, 0, -16384, 100);
    add_walk(4);
    drain();
    // long receiver hold while sender keeps going
    write_size(REG_SCREEN_WIDTH, 13'd16);
    write_size(REG_SCREEN_HEIGHT, 13'd12);
    hold_long = 1'b1;
    random_phase(60);
    repeat (400) @(posedge clk);
    hold_long = 1'b0;
    drain();
    write_size(REG_SCREEN_WIDTH, 13'd4096);
    write_size(REG_SCREEN_HEIGHT, 13'd4096);
    random_phase(150);
    drain();
    write_size(REG_SCREEN_WIDTH, SIZE_W'($urandom_range(1, 64)));
    write_size(REG_SCREEN_HEIGHT, SIZE_W'($urandom_range(1, 64)));
    random_phase(500);
    drain();
    write_size(REG_SCREEN_WIDTH, 13'd1);
    write_size(REG_SCREEN_HEIGHT, 13'd4097);
    random_phase(150);
    drain();
    write_size(REG_SCREEN_WIDTH, 13'd640);
    write_size(REG_SCREEN_HEIGHT, 13'd480);
    random_phase(150);
    quiet = 1'b1;
    drain();
    if (errors == 0) $display("tb_triangle_edge_rasterizer passed");
    else $display("tb_triangle_edge_rasterizer failed");
    $finish;
  end
endmodule
